// ===== sv/sbh_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and control types of the scaled bucket histogram.
package sbh_pkg;

  localparam int BUCKETS_DEF = 128;
  localparam int SAMPLE_W    = 31;
  localparam int SCALE_W     = 31;
  localparam int BUCKET_W    = 7;
  localparam int COUNT_W     = 32;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 31'h7FFF_FFFF;

  localparam logic [ADDR_W-3:0] REG_FULL_SCALE = 1'b0;

  localparam logic MODE_ACC  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic go;
    logic incr;
    logic clear;
  } mem_cmd_t;

  typedef struct packed {
    logic ready;
    logic done;
  } mem_stat_t;

  typedef struct packed {
    logic done;
    logic clip;
  } map_stat_t;

endpackage

// ===== sv/sbh_ifs.sv =====
`timescale 1ns / 1ps
// Sample and result word channels of the scaled bucket histogram.
interface sbh_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [sbh_pkg::SAMPLE_W-1:0] sample;
  logic [sbh_pkg::BUCKET_W-1:0] read_bucket;
  logic                         clear_after_read;

  modport source (output valid, mode, sample, read_bucket, clear_after_read, input ready);
  modport sink (input valid, mode, sample, read_bucket, clear_after_read, output ready);
endinterface

interface sbh_out_if;
  logic                         valid;
  logic                         ready;
  logic [sbh_pkg::BUCKET_W-1:0] bucket;
  logic [sbh_pkg::COUNT_W-1:0]  count;
  logic                         clipped;

  modport source (output valid, bucket, count, clipped, input ready);
  modport sink (input valid, bucket, count, clipped, output ready);
endinterface

// ===== sv/sbh_cfg.sv =====
`timescale 1ns / 1ps
// APB register block holding the full scale setting.
module sbh_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbh_pkg::ADDR_W-1:0]   paddr,
  input  logic [sbh_pkg::DATA_W-1:0]   pwdata,
  output logic [sbh_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [sbh_pkg::SCALE_W-1:0]  full_scale
);
  import sbh_pkg::*;

  logic [SCALE_W-1:0] full_scale_r;
  logic [SCALE_W-1:0] full_scale_nxt;
  logic               reg_hit;
  logic               wr_en;

  assign pready         = 1'b1;
  assign reg_hit        = (paddr[ADDR_W-1:2] == REG_FULL_SCALE);
  assign wr_en          = psel & penable & pwrite & pready & reg_hit;
  assign full_scale_nxt = wr_en ? pwdata[SCALE_W-1:0] : full_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= SCALE_RESET;
    end else begin
      full_scale_r <= full_scale_nxt;
    end
  end

  assign prdata     = reg_hit ? DATA_W'(full_scale_r) : '0;
  assign full_scale = full_scale_r;

endmodule

// ===== sv/sbh_map.sv =====
`timescale 1ns / 1ps
// Bucket mapping unit: scale multiply followed by a bit-serial restoring divider.
module sbh_map #(
  parameter int BUCKETS = sbh_pkg::BUCKETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sbh_pkg::SAMPLE_W-1:0]  sample,
  input  logic [sbh_pkg::SCALE_W-1:0]   scale,
  output sbh_pkg::map_stat_t            stat,
  output logic [$clog2(BUCKETS)-1:0]    idx
);
  import sbh_pkg::*;

  localparam int AW = $clog2(BUCKETS);
  localparam int PW = SAMPLE_W + AW;
  localparam int CW = (AW > 1) ? $clog2(AW) : 1;
  localparam logic [AW-1:0] TOP = AW'(BUCKETS - 1);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} state_t;

  state_t              state_r;
  logic                done_r;
  logic                clip_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SCALE_W-1:0]  div_r;
  logic [SCALE_W-1:0]  rem_r;
  logic [AW-1:0]       lo_r;
  logic [AW-1:0]       q_r;
  logic [CW-1:0]       cnt_r;

  logic [SCALE_W-1:0]  scale_eff;
  logic [PW-1:0]       prod;
  logic [SCALE_W:0]    trial;
  logic [SCALE_W:0]    diff;
  logic                ge;
  logic [AW:0]         q_sh;
  logic [AW-1:0]       q_nxt;

  assign scale_eff = (scale == '0) ? SCALE_W'(1) : scale;
  assign prod      = PW'(sample_r) * PW'(TOP);
  assign trial     = {rem_r, lo_r[AW-1]};
  assign ge        = (trial >= {1'b0, div_r});
  assign diff      = trial - {1'b0, div_r};
  assign q_sh      = {q_r, ge};
  assign q_nxt     = q_sh[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            sample_r <= sample;
            div_r    <= scale_eff;
            clip_r   <= (sample > scale_eff);
            state_r  <= M_MUL;
          end
        end
        M_MUL: begin
          rem_r   <= prod[PW-1:AW];
          lo_r    <= prod[AW-1:0];
          q_r     <= '0;
          cnt_r   <= CW'(AW - 1);
          state_r <= M_DIV;
        end
        M_DIV: begin
          rem_r <= ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
          lo_r  <= lo_r << 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            done_r  <= 1'b1;
            state_r <= M_IDLE;
          end
        end
        default: begin
          state_r <= M_IDLE;
        end
      endcase
    end
  end

  assign idx       = clip_r ? TOP : q_r;
  assign stat.done = done_r;
  assign stat.clip = clip_r;

endmodule

// ===== sv/sbh_mem.sv =====
`timescale 1ns / 1ps
// Bucket count memory with read-modify-write sequencing and clearing pass.
module sbh_mem #(
  parameter int BUCKETS = sbh_pkg::BUCKETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sbh_pkg::mem_cmd_t            cmd,
  input  logic [$clog2(BUCKETS)-1:0]   addr,
  output sbh_pkg::mem_stat_t           stat,
  output logic [sbh_pkg::COUNT_W-1:0]  count
);
  import sbh_pkg::*;

  localparam int AW = $clog2(BUCKETS);
  localparam logic [AW-1:0] LAST = AW'(BUCKETS - 1);

  typedef enum logic [1:0] {C_CLEAR, C_IDLE, C_MOD} state_t;

  logic [COUNT_W-1:0] mem [BUCKETS];

  state_t             state_r;
  logic [AW-1:0]      clr_addr_r;
  logic [AW-1:0]      addr_r;
  logic               incr_r;
  logic               clear_r;
  logic [COUNT_W-1:0] rd_data_r;

  logic               we;
  logic [AW-1:0]      wa;
  logic [COUNT_W-1:0] wd;
  logic [COUNT_W-1:0] sum;

  assign sum = rd_data_r + COUNT_W'(1);

  always_comb begin
    we = 1'b0;
    wa = addr_r;
    wd = '0;
    case (state_r)
      C_CLEAR: begin
        we = 1'b1;
        wa = clr_addr_r;
      end
      C_MOD: begin
        we = incr_r | clear_r;
        wd = incr_r ? sum : '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= C_CLEAR;
      clr_addr_r <= '0;
    end else begin
      case (state_r)
        C_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == LAST) begin
            state_r <= C_IDLE;
          end
        end
        C_IDLE: begin
          if (cmd.go) begin
            addr_r  <= addr;
            incr_r  <= cmd.incr;
            clear_r <= cmd.clear;
            state_r <= C_MOD;
          end
        end
        C_MOD: begin
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign stat.ready = (state_r == C_IDLE);
  assign stat.done  = (state_r == C_MOD);
  assign count      = incr_r ? sum : rd_data_r;

endmodule

// ===== sv/scaled_bucket_histogram.sv =====
`timescale 1ns / 1ps
// Top level of the scaled bucket histogram.
// Histogram of BUCKETS 32-bit counts held in one synchronous memory. A mode 0 word
// maps its sample to floor(sample*(BUCKETS-1)/full_scale), clipping samples above
// full scale to the top bucket, then increments that count and returns it. A mode 1
// word returns one bucket's count and optionally clears it; an index past the last
// bucket returns zero. One word is in flight at a time: accumulate runs the scale
// multiply, then the serial divider at one quotient bit per cycle, then the memory
// read-modify-write; a read of a valid bucket goes straight to the memory
// read-modify-write. After reset the memory is cleared one entry per cycle, during
// which no word is accepted. A finished result waits in the output register while
// the next word is taken.
module scaled_bucket_histogram #(
  parameter int BUCKETS = sbh_pkg::BUCKETS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sbh_in_if.sink                      in_ch,
  sbh_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbh_pkg::ADDR_W-1:0]  paddr,
  input  logic [sbh_pkg::DATA_W-1:0]  pwdata,
  output logic [sbh_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import sbh_pkg::*;

  localparam int AW = $clog2(BUCKETS);
  localparam int IW = ((AW > BUCKET_W) ? AW : BUCKET_W) + 1;

  typedef enum logic [2:0] {S_IDLE, S_MAP, S_ISSUE, S_WAIT, S_OUT} state_t;

  logic [SCALE_W-1:0]  full_scale;
  map_stat_t           map_stat;
  logic [AW-1:0]       map_idx;
  logic                map_start;
  mem_cmd_t            mem_cmd;
  mem_stat_t           mem_stat;
  logic [COUNT_W-1:0]  mem_count;

  state_t              state_r;
  logic                incr_r;
  logic                clear_r;
  logic [AW-1:0]       addr_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic                clip_r;
  logic [COUNT_W-1:0]  count_r;
  logic                out_valid_r;
  logic [BUCKET_W-1:0] out_bucket_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_clipped_r;

  logic                in_accept;
  logic [IW-1:0]       rb_wide;
  logic                rb_ok;
  logic [IW-1:0]       idx_wide;

  sbh_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .full_scale (full_scale)
  );

  sbh_map #(.BUCKETS(BUCKETS)) u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (map_start),
    .sample (in_ch.sample),
    .scale  (full_scale),
    .stat   (map_stat),
    .idx    (map_idx)
  );

  sbh_mem #(.BUCKETS(BUCKETS)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mem_cmd),
    .addr  (addr_r),
    .stat  (mem_stat),
    .count (mem_count)
  );

  assign in_ch.ready   = (state_r == S_IDLE) & mem_stat.ready;
  assign in_accept     = in_ch.valid & in_ch.ready;
  assign map_start     = in_accept & (in_ch.mode == MODE_ACC);
  assign rb_wide       = IW'(in_ch.read_bucket);
  assign rb_ok         = (rb_wide < IW'(BUCKETS));
  assign idx_wide      = IW'(map_idx);
  assign mem_cmd.go    = (state_r == S_ISSUE);
  assign mem_cmd.incr  = incr_r;
  assign mem_cmd.clear = clear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            bucket_r <= in_ch.read_bucket;
            clip_r   <= 1'b0;
            count_r  <= '0;
            incr_r   <= (in_ch.mode == MODE_ACC);
            clear_r  <= in_ch.clear_after_read;
            addr_r   <= rb_wide[AW-1:0];
            if (in_ch.mode == MODE_ACC) begin
              state_r <= S_MAP;
            end else if (rb_ok) begin
              state_r <= S_ISSUE;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_MAP: begin
          if (map_stat.done) begin
            addr_r   <= map_idx;
            bucket_r <= idx_wide[BUCKET_W-1:0];
            clip_r   <= map_stat.clip;
            state_r  <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (mem_stat.done) begin
            count_r <= mem_count;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_bucket_r  <= bucket_r;
            out_count_r   <= count_r;
            out_clipped_r <= clip_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.bucket  = out_bucket_r;
  assign out_ch.count   = out_count_r;
  assign out_ch.clipped = out_clipped_r;

endmodule

// ===== sv/sbh_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the scaled bucket histogram, bound to the top level.
module sbh_checker #(
  parameter int BUCKETS = sbh_pkg::BUCKETS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sbh_pkg::BUCKET_W-1:0] out_bucket,
  input logic [sbh_pkg::COUNT_W-1:0]  out_count,
  input logic                        out_clipped
);
  import sbh_pkg::*;

  localparam logic [BUCKET_W-1:0] TOP_FIELD = BUCKET_W'(BUCKETS - 1);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or result shown straight after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_clip_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_bucket == TOP_FIELD)
    else $error("clipped result not in the top bucket");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_bucket))
    else $error("stalled result changed");

endmodule

bind scaled_bucket_histogram sbh_checker #(.BUCKETS(BUCKETS)) u_sbh_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_bucket  (out_ch.bucket),
  .out_count   (out_ch.count),
  .out_clipped (out_ch.clipped)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the scaled bucket histogram: word stimulus, count predictor, APB setup.
typedef struct packed {
  logic                         mode;
  logic [sbh_pkg::SAMPLE_W-1:0] sample;
  logic [sbh_pkg::BUCKET_W-1:0] read_bucket;
  logic                         clear_after_read;
} hist_word_t;

typedef struct packed {
  logic [sbh_pkg::BUCKET_W-1:0] bucket;
  logic [sbh_pkg::COUNT_W-1:0]  count;
  logic                         clipped;
} hist_result_t;

class hist_scoreboard;
  logic [sbh_pkg::SCALE_W-1:0] full_scale;
  logic [sbh_pkg::COUNT_W-1:0] counts [sbh_pkg::BUCKETS_DEF];
  hist_result_t                expected_q [$];
  int                          errors;

  function new();
    full_scale = sbh_pkg::SCALE_RESET;
    foreach (counts[i]) counts[i] = '0;
    errors = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_input(hist_word_t w);
    hist_result_t                r;
    logic [63:0]                 q;
    logic [sbh_pkg::SCALE_W-1:0] divisor;
    int                          idx;
    r = '0;
    if (w.mode == sbh_pkg::MODE_ACC) begin
      divisor = (full_scale == '0) ? sbh_pkg::SCALE_W'(1) : full_scale;
      if (w.sample > divisor) begin
        idx = sbh_pkg::BUCKETS_DEF - 1;
        r.clipped = 1'b1;
      end else begin
        q = (64'(w.sample) * 64'(sbh_pkg::BUCKETS_DEF - 1)) / 64'(divisor);
        idx = (q > 64'(sbh_pkg::BUCKETS_DEF - 1)) ? sbh_pkg::BUCKETS_DEF - 1 : int'(q);
      end
      counts[idx] = counts[idx] + 1'b1;
      r.count = counts[idx];
    end else begin
      idx = int'(w.read_bucket);
      if (idx < sbh_pkg::BUCKETS_DEF) begin
        r.count = counts[idx];
        if (w.clear_after_read) counts[idx] = '0;
      end
    end
    r.bucket = idx[sbh_pkg::BUCKET_W-1:0];
    expected_q.push_back(r);
  endfunction

  function void check_result(hist_result_t got);
    hist_result_t exp_r;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result bucket %0d count %0d clipped %0b",
               $time, got.bucket, got.count, got.clipped);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.bucket !== exp_r.bucket) begin
      $display("%0t: bucket expected %0d actual %0d", $time, exp_r.bucket, got.bucket);
      errors++;
    end
    if (got.count !== exp_r.count) begin
      $display("%0t: count expected %0d actual %0d", $time, exp_r.count, got.count);
      errors++;
    end
    if (got.clipped !== exp_r.clipped) begin
      $display("%0t: clipped expected %0b actual %0b", $time, exp_r.clipped, got.clipped);
      errors++;
    end
  endfunction
endclass

module testbench;
  import sbh_pkg::*;

  localparam logic [SCALE_W-1:0] SCALE_MAX = 31'h7FFF_FFFF;
  localparam int PHASE_WORDS = 205;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  bit                steady;
  int                cycles = 0;

  sbh_in_if  in_ch ();
  sbh_out_if out_ch ();

  hist_scoreboard sb = new();

  scaled_bucket_histogram DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= rst_n && (steady || $urandom_range(99) >= 29);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.bucket, out_ch.count, out_ch.clipped});
    end
  end

  function automatic bit idle_roll();
    return !steady && $urandom_range(99) < 29;
  endfunction

  task automatic send_word(input hist_word_t w);
    @(negedge clk);
    while (idle_roll()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.mode             <= w.mode;
    in_ch.sample           <= w.sample;
    in_ch.read_bucket      <= w.read_bucket;
    in_ch.clear_after_read <= w.clear_after_read;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(w);
  endtask

  task automatic accumulate(input logic [SAMPLE_W-1:0] s);
    send_word('{MODE_ACC, s, BUCKET_W'($urandom_range(127)), 1'($urandom_range(1))});
  endtask

  task automatic read_count(input logic [BUCKET_W-1:0] b, input logic clr);
    send_word('{MODE_READ, SAMPLE_W'($urandom()), b, clr});
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FULL_SCALE, 2'b00};
    pwdata  <= {1'b0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.full_scale = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[SCALE_W-1:0] !== v) begin
      $display("%0t: full_scale read expected %0d actual %0d", $time, v, prdata[SCALE_W-1:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SCALE_W-1:0] scale);
    int     sel;
    longint e;
    sel = $urandom_range(99);
    if (sel < 40) return SAMPLE_W'($urandom_range(scale));
    if (sel < 55) begin
      e = (longint'($urandom_range(127)) * longint'(scale) + 126) / 127;
      e = e + longint'($urandom_range(2)) - 1;
      if (e < 0) e = 0;
      if (e > longint'(SCALE_MAX)) e = longint'(SCALE_MAX);
      return e[SAMPLE_W-1:0];
    end
    if (sel < 70)
      return (scale == SCALE_MAX) ? SCALE_MAX :
             SAMPLE_W'($urandom_range(SCALE_MAX, scale + 1));
    if (sel < 85) return SAMPLE_W'($urandom());
    if (sel < 93) return SAMPLE_W'($urandom_range(3));
    return (scale == '0) ? '0 : scale - SCALE_W'($urandom_range(1));
  endfunction

  task automatic run_phase(input logic [SCALE_W-1:0] scale, input bit hold_mid);
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (hold_mid && i == PHASE_WORDS / 2) drain();
      if ($urandom_range(99) < 75) accumulate(pick_sample(scale));
      else read_count(BUCKET_W'($urandom_range(127)), 1'($urandom_range(1)));
    end
    drain();
  endtask

  initial begin
    logic [SCALE_W-1:0] scales [8];
    rst_n                  = 1'b0;
    steady                 = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.mode             = MODE_ACC;
    in_ch.sample           = '0;
    in_ch.read_bucket      = '0;
    in_ch.clear_after_read = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    accumulate('0);
    accumulate(SCALE_MAX);
    accumulate(SCALE_MAX - 31'd1);
    accumulate(31'h4000_0000);
    read_count(7'd0, 1'b0);
    read_count(7'd127, 1'b1);
    read_count(7'd127, 1'b0);
    read_count(7'd5, 1'b1);
    drain();
    write_scale(31'd1);
    accumulate('0);
    accumulate(31'd1);
    accumulate(31'd2);
    accumulate(SCALE_MAX);
    read_count(7'd127, 1'b1);
    drain();
    write_scale(31'd254);
    accumulate(31'd127);
    accumulate(31'd128);
    accumulate(31'd253);
    accumulate(31'd254);
    accumulate(31'd255);
    read_count(7'd63, 1'b0);
    drain();

    scales = '{SCALE_MAX, 31'd1, 31'd127, 31'd1000, SCALE_W'($urandom_range(SCALE_MAX, 1)),
               31'h4000_0000, SCALE_MAX - 31'd1, SCALE_MAX};
    foreach (scales[p]) begin
      write_scale(scales[p]);
      steady = (p == 3);
      run_phase(scales[p], p == 5);
    end
    steady = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
